// ----- src/hvnf_pkg.sv -----
// Shared constants, types and a constant function for the value noise generator.
package hvnf_pkg;

   localparam int OCTAVES       = 4;
   localparam int FRACTION_BITS = 24;
   localparam int COORD_W       = 48;
   localparam int HI_W          = COORD_W - FRACTION_BITS;
   localparam int COEF_W        = FRACTION_BITS + 2;
   localparam int ACC_W         = FRACTION_BITS + 2;
   localparam int OUT_W         = 17;

   localparam logic [63:0] ONE_F     = 64'd1 << FRACTION_BITS;
   localparam logic [63:0] HALF_F    = 64'd1 << (FRACTION_BITS - 1);
   localparam logic [63:0] COEF_A    = ((64'd1624 << FRACTION_BITS) + 64'd500) / 64'd1000;
   localparam logic [63:0] COEF_B    = ((64'd1218 << FRACTION_BITS) + 64'd500) / 64'd1000;
   localparam logic [63:0] OFF_X     = ((64'd137 << FRACTION_BITS) + 64'd5) / 64'd10;
   localparam logic [63:0] OFF_Z     = ((64'd79 << FRACTION_BITS) + 64'd5) / 64'd10;
   localparam logic [63:0] AMP_START = ((64'd56 << FRACTION_BITS) + 64'd50) / 64'd100;
   localparam logic [63:0] AMP_DECAY = ((64'd48 << FRACTION_BITS) + 64'd50) / 64'd100;

   localparam logic [63:0] MIX_C1 = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_C2 = 64'h94D049BB133111EB;
   localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] ZSALT  = 64'hD1B54A32D192ED03;

   typedef logic [COORD_W-1:0]       coord_type;
   typedef logic [ACC_W-1:0]         acc_type;
   typedef logic [FRACTION_BITS-1:0] unit_type;
   typedef logic [FRACTION_BITS:0]   weight_type;

   function automatic logic [63:0] amp_of(input int oct);
      logic [63:0] a;
      a = AMP_START;
      for (int i = 0; i < oct; i++) begin
         a = (a * AMP_DECAY + HALF_F) >> FRACTION_BITS;
      end
      return a;
   endfunction

endpackage

// ----- src/hashed_value_noise_fbm.sv -----
// A request passes through the four octave pipelines and then the output register.
// Throughput: one request per cycle; the whole pipeline holds while a result is stalled.
// Each octave stage is paced by its two chained 64-bit scramblers of 4 stages each.
// Reset (synchronous, active high) clears all valid bits and the seed register to zero.
// Top level: four-octave fractal sum of hashed 2-D value noise.
module hashed_value_noise_fbm (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [47:0]           req_x_coord,
   input  logic signed [47:0]           req_z_coord,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [hvnf_pkg::OUT_W-1:0]   rsp_noise_value,
   input  logic                         csr_wr_en,
   input  logic [63:0]                  csr_wr_data
);
   import hvnf_pkg::*;

   logic [63:0]      seed_ff;
   logic             en;
   logic             valid_c [0:OCTAVES];
   coord_type        px_c [0:OCTAVES];
   coord_type        pz_c [0:OCTAVES];
   acc_type          acc_c [0:OCTAVES];
   acc_type          sat;
   logic [OUT_W-1:0] q_in;
   logic [OUT_W-1:0] clip_in;
   logic             rsp_valid_ff;
   logic [OUT_W-1:0] rsp_value_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 64'd0;
      end else if (csr_wr_en) begin
         seed_ff <= csr_wr_data;
      end
   end

   assign valid_c[0] = req_valid;
   assign px_c[0]    = req_x_coord;
   assign pz_c[0]    = req_z_coord;
   assign acc_c[0]   = '0;

   for (genvar g = 0; g < OCTAVES; g++) begin : g_oct
      localparam logic [63:0] SEED_OFF = 64'(g) * GOLDEN;
      localparam unit_type    AMP      = FRACTION_BITS'(amp_of(g));
      hvnf_octave u_oct (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (valid_c[g]),
         .in_px     (px_c[g]),
         .in_pz     (pz_c[g]),
         .in_acc    (acc_c[g]),
         .seed      (seed_ff + SEED_OFF),
         .amp       (AMP),
         .out_valid (valid_c[g+1]),
         .out_px    (px_c[g+1]),
         .out_pz    (pz_c[g+1]),
         .out_acc   (acc_c[g+1])
      );
   end

   assign sat = (acc_c[OCTAVES] > ACC_W'(ONE_F)) ? ACC_W'(ONE_F) : acc_c[OCTAVES];

   if (FRACTION_BITS > 16) begin : g_round
      localparam int Q_SH = FRACTION_BITS - 16;
      logic [ACC_W:0] rnd;
      assign rnd  = {1'b0, sat} + ((ACC_W+1)'(1) << (Q_SH - 1));
      assign q_in = OUT_W'(rnd >> Q_SH);
   end else if (FRACTION_BITS == 16) begin : g_same
      assign q_in = OUT_W'(sat);
   end else begin : g_widen
      assign q_in = OUT_W'(sat) << (16 - FRACTION_BITS);
   end

   assign clip_in = (q_in > OUT_W'(65536)) ? OUT_W'(65536) : q_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= valid_c[OCTAVES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_value_ff <= clip_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_value_ff;

endmodule

// ----- src/hvnf_mix64.sv -----
// Four-stage pipelined 64-bit splitmix-style scrambler.
module hvnf_mix64 (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] din,
   output logic [63:0] dout
);
   import hvnf_pkg::*;

   logic [63:0] x_in, y_in;
   logic [63:0] xll_in, xhl_in, xlh_in, yll_in, yhl_in, ylh_in;
   logic [63:0] p1ll_ff, p2ll_ff, m1_ff, m2_ff;
   logic [31:0] p1hl_ff, p1lh_ff, p2hl_ff, p2lh_ff;

   always_comb begin
      x_in   = din ^ (din >> 30);
      xll_in = x_in[31:0] * MIX_C1[31:0];
      xhl_in = x_in[63:32] * MIX_C1[31:0];
      xlh_in = x_in[31:0] * MIX_C1[63:32];
      y_in   = m1_ff ^ (m1_ff >> 27);
      yll_in = y_in[31:0] * MIX_C2[31:0];
      yhl_in = y_in[63:32] * MIX_C2[31:0];
      ylh_in = y_in[31:0] * MIX_C2[63:32];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1ll_ff <= xll_in;
         p1hl_ff <= xhl_in[31:0];
         p1lh_ff <= xlh_in[31:0];
         m1_ff   <= p1ll_ff + {p1hl_ff + p1lh_ff, 32'd0};
         p2ll_ff <= yll_in;
         p2hl_ff <= yhl_in[31:0];
         p2lh_ff <= ylh_in[31:0];
         m2_ff   <= p2ll_ff + {p2hl_ff + p2lh_ff, 32'd0};
      end
   end

   assign dout = m2_ff ^ (m2_ff >> 31);

endmodule

// ----- src/hvnf_octave.sv -----
// One octave: lattice hashing, smoothstep blend, amplitude sum and point transform.
module hvnf_octave (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  hvnf_pkg::coord_type  in_px,
   input  hvnf_pkg::coord_type  in_pz,
   input  hvnf_pkg::acc_type    in_acc,
   input  logic [63:0]          seed,
   input  hvnf_pkg::unit_type   amp,
   output logic                 out_valid,
   output hvnf_pkg::coord_type  out_px,
   output hvnf_pkg::coord_type  out_pz,
   output hvnf_pkg::acc_type    out_acc
);
   import hvnf_pkg::*;

   localparam int F    = FRACTION_BITS;
   localparam int PH_W = HI_W + COEF_W + 1;
   localparam int PL_W = F + COEF_W;
   localparam logic [COEF_W-1:0] CA    = COEF_W'(COEF_A);
   localparam logic [COEF_W-1:0] CB    = COEF_W'(COEF_B);
   localparam weight_type        ONE_W = weight_type'(ONE_F);

   // lattice hash
   logic [63:0] ix, iz;
   logic [63:0] hin [4];
   logic [63:0] hout [4];
   logic [63:0] cm_ff [4];
   logic [63:0] cout [4];
   unit_type    cv [4];

   assign ix = 64'(signed'(in_px[COORD_W-1:F]));
   assign iz = 64'(signed'(in_pz[COORD_W-1:F]));
   assign hin[0] = ix + GOLDEN;
   assign hin[1] = ix + GOLDEN + 64'd1;
   assign hin[2] = iz + ZSALT;
   assign hin[3] = iz + ZSALT + 64'd1;

   for (genvar k = 0; k < 4; k++) begin : g_hash
      hvnf_mix64 u_axis (.clock(clock), .en(en), .din(hin[k]), .dout(hout[k]));
      hvnf_mix64 u_corner (.clock(clock), .en(en), .din(cm_ff[k]), .dout(cout[k]));
      assign cv[k] = cout[k][63 -: F];
   end

   // smoothstep, index 0 for x and 1 for z
   unit_type            fin [2];
   unit_type            f_ff [2];
   unit_type            sq_ff [2];
   unit_type            sq2_ff [2];
   unit_type            cube_ff [2];
   logic [2*F-1:0]      sq_in [2];
   logic [2*F-1:0]      cube_in [2];
   logic [F+1:0]        poly_in [2];
   weight_type          s_in [2];
   weight_type          s_ff [2][3:11];

   assign fin[0] = in_px[F-1:0];
   assign fin[1] = in_pz[F-1:0];

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         sq_in[a]   = fin[a] * fin[a];
         cube_in[a] = sq_ff[a] * f_ff[a];
         poly_in[a] = ({2'b00, sq2_ff[a]} << 1) + {2'b00, sq2_ff[a]}
                      - ({2'b00, cube_ff[a]} << 1);
         s_in[a]    = (poly_in[a] > (F+2)'(ONE_W)) ? ONE_W : poly_in[a][F:0];
      end
   end

   // blend and accumulate
   logic [2*F:0]   pa_ff, pb_ff, pc_ff, pd_ff, qa_ff, qb_ff;
   logic [2*F+1:0] sab_in, scd_in, sq_sum_in;
   unit_type       l0_ff, l1_ff, n_ff;
   logic [2*F-1:0] w_ff;
   acc_type        acc_ff [1:15];

   assign sab_in    = {1'b0, pa_ff} + {1'b0, pb_ff};
   assign scd_in    = {1'b0, pc_ff} + {1'b0, pd_ff};
   assign sq_sum_in = {1'b0, qa_ff} + {1'b0, qb_ff};

   // point transform
   logic signed [HI_W-1:0] hx, hz;
   logic signed [PH_W-1:0] ph_in [4];
   logic [PL_W-1:0]        pl_in [4];
   logic signed [PH_W-1:0] ph_ff [4];
   logic [PL_W-1:0]        pl_ff [4];
   coord_type              mf_ff [4];
   coord_type              nx_ff [3:15];
   coord_type              nz_ff [3:15];

   assign hx = in_px[COORD_W-1:F];
   assign hz = in_pz[COORD_W-1:F];

   always_comb begin
      ph_in[0] = hx * $signed({1'b0, CA});
      ph_in[1] = hz * $signed({1'b0, CB});
      ph_in[2] = hx * $signed({1'b0, CB});
      ph_in[3] = hz * $signed({1'b0, CA});
      pl_in[0] = in_px[F-1:0] * CA;
      pl_in[1] = in_pz[F-1:0] * CB;
      pl_in[2] = in_px[F-1:0] * CB;
      pl_in[3] = in_pz[F-1:0] * CA;
   end

   logic valid_ff [1:15];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= 15; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         valid_ff[1] <= in_valid;
         for (int k = 2; k <= 15; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cm_ff[0] <= seed ^ hout[0] ^ hout[2];
         cm_ff[1] <= seed ^ hout[1] ^ hout[2];
         cm_ff[2] <= seed ^ hout[0] ^ hout[3];
         cm_ff[3] <= seed ^ hout[1] ^ hout[3];

         for (int a = 0; a < 2; a++) begin
            f_ff[a]    <= fin[a];
            sq_ff[a]   <= sq_in[a][2*F-1:F];
            sq2_ff[a]  <= sq_ff[a];
            cube_ff[a] <= cube_in[a][2*F-1:F];
            s_ff[a][3] <= s_in[a];
            for (int k = 4; k <= 11; k++) s_ff[a][k] <= s_ff[a][k-1];
         end

         pa_ff <= cv[0] * (ONE_W - s_ff[0][9]);
         pb_ff <= cv[1] * s_ff[0][9];
         pc_ff <= cv[2] * (ONE_W - s_ff[0][9]);
         pd_ff <= cv[3] * s_ff[0][9];
         l0_ff <= sab_in[2*F-1:F];
         l1_ff <= scd_in[2*F-1:F];
         qa_ff <= l0_ff * (ONE_W - s_ff[1][11]);
         qb_ff <= l1_ff * s_ff[1][11];
         n_ff  <= sq_sum_in[2*F-1:F];
         w_ff  <= n_ff * amp;

         acc_ff[1] <= in_acc;
         for (int k = 2; k <= 14; k++) acc_ff[k] <= acc_ff[k-1];
         acc_ff[15] <= acc_ff[14] + ACC_W'(w_ff[2*F-1:F]);

         for (int k = 0; k < 4; k++) begin
            ph_ff[k] <= ph_in[k];
            pl_ff[k] <= pl_in[k];
            mf_ff[k] <= COORD_W'(ph_ff[k]) + COORD_W'(pl_ff[k][PL_W-1:F]);
         end
         nx_ff[3] <= mf_ff[0] - mf_ff[1] + OFF_X[COORD_W-1:0];
         nz_ff[3] <= mf_ff[2] + mf_ff[3] + OFF_Z[COORD_W-1:0];
         for (int k = 4; k <= 15; k++) begin
            nx_ff[k] <= nx_ff[k-1];
            nz_ff[k] <= nz_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[15];
   assign out_px    = nx_ff[15];
   assign out_pz    = nz_ff[15];
   assign out_acc   = acc_ff[15];

endmodule

// ----- src/hvnf_checker.sv -----
// Port-level checks for the noise generator, bound to the top level.
module hvnf_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [hvnf_pkg::OUT_W-1:0] rsp_noise_value
);
   import hvnf_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_noise_value))
      else $error("stalled result changed");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_noise_value <= OUT_W'(65536))
      else $error("result above one");

   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("request stalled while output free");

endmodule

bind hashed_value_noise_fbm hvnf_checker u_hvnf_checker (.*);
